// ===== rtl/keccak_p200_x4_permutation_top_assert.svh =====
// assertion macros for the four-way keccak-p[200] permutation
// expects clk_i and rst_ni in the scope of use
`ifndef KECCAK_P200_X4_PERMUTATION_TOP_ASSERT_SVH
`define KECCAK_P200_X4_PERMUTATION_TOP_ASSERT_SVH

// property holds at every edge outside reset
`define KP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition never seen outside reset
`define KP_ASSERT_NEVER(lbl, cond, msg) \
  `KP_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/kp200x4_pkg.sv =====
`timescale 1ns / 1ps
// types, constants and round function of the four-way keccak-p[200] permutation
// no dependencies
package kp200x4_pkg;

  localparam int unsigned NLanes    = 25;
  localparam int unsigned WordW     = 32;
  localparam int unsigned MaxRounds = 18;
  localparam int unsigned Rounds    = 18;
  localparam int unsigned CntW      = 5;
  localparam int unsigned RcW       = 5;

  localparam logic [CntW-1:0] LastLane  = CntW'(NLanes - 1);
  localparam logic [CntW-1:0] LastRound = CntW'(Rounds - 1);
  localparam logic [RcW-1:0]  RcBase    = RcW'(MaxRounds - Rounds);

  typedef logic [WordW-1:0]            word_t;
  typedef logic [NLanes-1:0][WordW-1:0] lanes_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RUN,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic           load;
    logic           round;
    logic           emit;
    logic [RcW-1:0] rc_idx;
  } ctrl_cmd_t;

  // rho offsets in lane bits
  localparam logic [2:0] RhoTab [NLanes] = '{
    3'd0, 3'd1, 3'd6, 3'd4, 3'd3, 3'd4, 3'd4, 3'd6, 3'd7, 3'd4, 3'd3, 3'd2, 3'd3,
    3'd1, 3'd7, 3'd1, 3'd5, 3'd7, 3'd5, 3'd0, 3'd2, 3'd2, 3'd5, 3'd0, 3'd6
  };

  function automatic word_t iota_const(logic [RcW-1:0] idx);
    word_t rc;
    case (idx)
      5'd0:    rc = 32'h0000000f;
      5'd1:    rc = 32'hf00000f0;
      5'd2:    rc = 32'hf000f0f0;
      5'd3:    rc = 32'h00000000;
      5'd4:    rc = 32'hf000f0ff;
      5'd5:    rc = 32'h0000000f;
      5'd6:    rc = 32'hf000000f;
      5'd7:    rc = 32'h0000f00f;
      5'd8:    rc = 32'hf000f0f0;
      5'd9:    rc = 32'hf000f000;
      5'd10:   rc = 32'h0000f00f;
      5'd11:   rc = 32'h0000f0f0;
      5'd12:   rc = 32'hf000f0ff;
      5'd13:   rc = 32'hf000f0ff;
      5'd14:   rc = 32'hf000f00f;
      5'd15:   rc = 32'h000000ff;
      5'd16:   rc = 32'h000000f0;
      5'd17:   rc = 32'hf0000000;
      default: rc = 32'h00000000;
    endcase
    return rc;
  endfunction

  // lane rotation by r bits is a word rotation by 4r
  function automatic word_t rotl_lane(word_t v, logic [2:0] r);
    logic [2*WordW-1:0] t;
    t = {v, v} << {r, 2'b00};
    return t[2*WordW-1:WordW];
  endfunction

  function automatic lanes_t kp_round(lanes_t a, word_t rc);
    word_t  c [5];
    word_t  d [5];
    lanes_t e;
    lanes_t b;
    lanes_t r;
    for (int x = 0; x < 5; x++) begin
      c[x] = a[x] ^ a[x+5] ^ a[x+10] ^ a[x+15] ^ a[x+20];
    end
    for (int x = 0; x < 5; x++) begin
      d[x] = rotl_lane(c[(x+1)%5], 3'd1) ^ c[(x+4)%5];
    end
    for (int i = 0; i < 25; i++) begin
      e[i] = a[i] ^ d[i%5];
    end
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 5; x++) begin
        b[y + 5*((2*x + 3*y) % 5)] = rotl_lane(e[x + 5*y], RhoTab[x + 5*y]);
      end
    end
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 5; x++) begin
        r[x + 5*y] = b[x + 5*y] ^ (~b[(x+1)%5 + 5*y] & b[(x+2)%5 + 5*y]);
      end
    end
    r[0] = r[0] ^ rc;
    return r;
  endfunction

endpackage

// ===== rtl/kp200x4_in_if.sv =====
`timescale 1ns / 1ps
// input channel: one lane word per transfer
// depends on kp200x4_pkg
interface kp200x4_in_if;
  import kp200x4_pkg::*;

  logic  valid;
  logic  ready;
  word_t lane_word;

  modport source (output valid, output lane_word, input ready);
  modport sink   (input valid, input lane_word, output ready);
endinterface

// ===== rtl/kp200x4_out_if.sv =====
`timescale 1ns / 1ps
// output channel: one permuted lane word per transfer with last flag
// depends on kp200x4_pkg
interface kp200x4_out_if;
  import kp200x4_pkg::*;

  logic  valid;
  logic  ready;
  word_t lane_result;
  logic  last_lane;

  modport source (output valid, output lane_result, output last_lane, input ready);
  modport sink   (input valid, input lane_result, input last_lane, output ready);
endinterface

// ===== rtl/kp200x4_dpath.sv =====
`timescale 1ns / 1ps
// datapath: 25-word state shift line and one-round-per-cycle permutation unit
// depends on kp200x4_pkg
module kp200x4_dpath (
  input  logic                   clk_i,
  input  kp200x4_pkg::ctrl_cmd_t cmd_i,
  input  kp200x4_pkg::word_t     lane_word_i,
  output kp200x4_pkg::word_t     lane_result_o
);
  import kp200x4_pkg::*;

  lanes_t lanes_q;
  lanes_t lanes_d;

  always_comb begin
    lanes_d = lanes_q;
    if (cmd_i.load) begin
      lanes_d = {lane_word_i, lanes_q[NLanes-1:1]};
    end else if (cmd_i.round) begin
      lanes_d = kp_round(lanes_q, iota_const(cmd_i.rc_idx));
    end else if (cmd_i.emit) begin
      lanes_d = {lanes_q[0], lanes_q[NLanes-1:1]};
    end
  end

  always_ff @(posedge clk_i) begin
    lanes_q <= lanes_d;
  end

  assign lane_result_o = lanes_q[0];
endmodule

// ===== rtl/kp200x4_ctrl.sv =====
`timescale 1ns / 1ps
// controller: load, round and emit sequencing with one shared beat counter
// depends on kp200x4_pkg
module kp200x4_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   last_lane_o,
  output kp200x4_pkg::ctrl_cmd_t cmd_o
);
  import kp200x4_pkg::*;

  ctrl_state_e     state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    last_lane_o  = 1'b0;
    cmd_o        = '0;
    cmd_o.rc_idx = cnt_q + RcBase;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (cnt_q == LastLane) begin
            state_d = ST_RUN;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      ST_RUN: begin
        cmd_o.round = 1'b1;
        if (cnt_q == LastRound) begin
          state_d = ST_EMIT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        last_lane_o = (cnt_q == LastLane);
        if (out_ready_i) begin
          cmd_o.emit = 1'b1;
          if (cnt_q == LastLane) begin
            state_d = ST_LOAD;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
        cnt_d   = '0;
      end
    endcase
  end
endmodule

// ===== rtl/keccak_p200_x4_permutation_top.sv =====
`timescale 1ns / 1ps
// four-way bit-interleaved keccak-p[200] permutation, 25 words in, 25 words out
// after the 25th input word the rounds run, then one output word per cycle while out_o.ready is high
// a new batch is loaded only after all 25 words of the last one are emitted
// the single state register and its one-round unit are shared by all three phases
// async active-low reset returns the controller to loading with an empty count
module keccak_p200_x4_permutation_top (
  input  logic clk_i,
  input  logic rst_ni,
  kp200x4_in_if.sink    in_i,
  kp200x4_out_if.source out_o
);
  import kp200x4_pkg::*;

  ctrl_cmd_t cmd;

  kp200x4_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .last_lane_o (out_o.last_lane),
    .cmd_o       (cmd)
  );

  kp200x4_dpath u_dpath (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .lane_word_i   (in_i.lane_word),
    .lane_result_o (out_o.lane_result)
  );

`include "keccak_p200_x4_permutation_top_assert.svh"

  `KP_ASSERT_NEVER(a_load_emit_excl, in_i.ready && out_o.valid, "load and emit overlap")
  `KP_ASSERT(a_last_to_load, out_o.valid && out_o.ready && out_o.last_lane |=> in_i.ready, "no reload after last word")
  `KP_ASSERT(a_emit_after_run, $rose(out_o.valid) |-> !$past(in_i.ready), "emit without rounds")
  `KP_ASSERT_NEVER(a_cmd_onehot, !$onehot0({cmd.load, cmd.round, cmd.emit}), "conflicting datapath commands")
endmodule

// ===== sim/tb_keccak_p200_x4_permutation_top.sv =====
`timescale 1ns / 1ps
// self-checking bench for the four-way interleaved keccak-p[200] permutation top
// predicts each 25-word result block from its own round model; uses kp200x4_pkg and both channel interfaces
module tb_keccak_p200_x4_permutation_top;
  import kp200x4_pkg::*;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned TailCycles = 40;
  localparam int unsigned IdlePct    = 14;
  localparam int unsigned MaxReports = 10;

  localparam word_t RoundConst [MaxRounds] = '{
    32'h0000000f, 32'hf00000f0, 32'hf000f0f0, 32'h00000000, 32'hf000f0ff, 32'h0000000f,
    32'hf000000f, 32'h0000f00f, 32'hf000f0f0, 32'hf000f000, 32'h0000f00f, 32'h0000f0f0,
    32'hf000f0ff, 32'hf000f0ff, 32'hf000f00f, 32'h000000ff, 32'h000000f0, 32'hf0000000
  };

  // lane rotation in lane bits
  localparam int unsigned RhoOff [NLanes] = '{
    0, 1, 6, 4, 3, 4, 4, 6, 7, 4, 3, 2, 3, 1, 7, 1, 5, 7, 5, 0, 2, 2, 5, 0, 6
  };

  typedef struct packed {
    word_t lane;
    logic  last;
  } lane_expect_t;

  logic clk_i;
  logic rst_ni;

  kp200x4_in_if  in_if ();
  kp200x4_out_if out_if ();

  keccak_p200_x4_permutation_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  lane_expect_t lane_expect_q[$];
  lanes_t       lane_batch;
  int unsigned  batch_fill;
  int unsigned  mismatch_cnt;
  int unsigned  result_cnt;
  int unsigned  stall_cnt;
  int unsigned  hold_req;
  int unsigned  hold_left;
  bit           idle_on;

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  function automatic word_t rot_word(word_t v, int unsigned n);
    n = n % 32;
    if (n == 0) begin
      return v;
    end
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic lanes_t keccak_round(lanes_t a, int unsigned rc);
    word_t  col [5];
    word_t  mix [5];
    lanes_t b;
    lanes_t r;
    for (int x = 0; x < 5; x++) begin
      col[x] = a[x] ^ a[x+5] ^ a[x+10] ^ a[x+15] ^ a[x+20];
    end
    for (int x = 0; x < 5; x++) begin
      mix[x] = rot_word(col[(x+1)%5], 4) ^ col[(x+4)%5];
    end
    for (int i = 0; i < NLanes; i++) begin
      a[i] = a[i] ^ mix[i%5];
    end
    // rho and pi: lane (x,y) moves to (y, 2x+3y)
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 5; x++) begin
        b[y + 5*((2*x + 3*y) % 5)] = rot_word(a[x + 5*y], 4 * RhoOff[x + 5*y]);
      end
    end
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 5; x++) begin
        r[x + 5*y] = b[x + 5*y] ^ (~b[(x+1)%5 + 5*y] & b[(x+2)%5 + 5*y]);
      end
    end
    r[0] = r[0] ^ RoundConst[rc];
    return r;
  endfunction

  task automatic absorb_lane(input word_t w);
    lane_expect_t e;
    lane_batch[batch_fill] = w;
    batch_fill++;
    if (batch_fill == NLanes) begin
      for (int unsigned rc = MaxRounds - Rounds; rc < MaxRounds; rc++) begin
        lane_batch = keccak_round(lane_batch, rc);
      end
      for (int k = 0; k < NLanes; k++) begin
        e.lane = lane_batch[k];
        e.last = (k == NLanes - 1);
        lane_expect_q.push_back(e);
      end
      batch_fill = 0;
    end
  endtask

  function automatic word_t rand_lane();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1) << $urandom_range(WordW - 1);
      3:       return ~(word_t'(1) << $urandom_range(WordW - 1));
      default: return $urandom;
    endcase
  endfunction

  task automatic send_lane(input word_t w);
    while (idle_on && $urandom_range(99) < IdlePct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.lane_word <= w;
    @(posedge clk_i);
    while (!in_if.ready) begin
      @(posedge clk_i);
    end
    absorb_lane(w);
  endtask

  task automatic send_batches(input int unsigned n);
    repeat (n * NLanes) begin
      send_lane(rand_lane());
    end
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (lane_expect_q.size() != 0);
  endtask

  task automatic test_directed_lanes();
    word_t w;
    for (int k = 0; k < NLanes; k++) begin
      case (k)
        1:       w = '1;
        2:       w = 32'h80000000;
        3:       w = 32'h00000001;
        4:       w = 32'haaaaaaaa;
        5:       w = 32'h55555555;
        6:       w = 32'h0000000f;
        7:       w = 32'hf0000000;
        24:      w = '1;
        default: w = '0;
      endcase
      send_lane(w);
    end
    drain_results();
    // all-zero state leaves only the round constants at work
    repeat (NLanes) begin
      send_lane('0);
    end
    drain_results();
  endtask

  task automatic test_random_lanes();
    send_batches(4);
  endtask

  task automatic test_idle_free_stream();
    idle_on = 1'b0;
    send_batches(3);
    drain_results();
    idle_on = 1'b1;
  endtask

  task automatic test_result_backpressure();
    hold_req = 300;
    send_batches(3);
  endtask

  task automatic test_drain_pause();
    drain_results();
    repeat (2) begin
      send_batches(1);
      drain_results();
    end
  endtask

  // result side ready, with random idling and long hold-offs
  always @(posedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(99) < IdlePct) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // result check and watchdog
  always @(posedge clk_i) begin
    lane_expect_t e;
    bit           moved;
    moved = 1'b0;
    if (rst_ni && in_if.valid && in_if.ready) begin
      moved = 1'b1;
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      moved = 1'b1;
      if (lane_expect_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MaxReports) begin
          $display("unexpected word %0d: lane_result %h last_lane %b", result_cnt,
                   out_if.lane_result, out_if.last_lane);
        end
      end else begin
        e = lane_expect_q.pop_front();
        if (out_if.lane_result !== e.lane || out_if.last_lane !== e.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxReports) begin
            $display("word %0d mismatch: lane_result exp %h got %h, last_lane exp %b got %b",
                     result_cnt, e.lane, out_if.lane_result, e.last, out_if.last_lane);
          end
        end
      end
      result_cnt++;
    end
    if (moved || !rst_ni) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
      if (stall_cnt >= StallLimit) begin
        $display("timeout after %0d cycles without a transfer", stall_cnt);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.lane_word = '0;
    out_if.ready    = 1'b0;
    lane_batch      = '0;
    batch_fill      = 0;
    mismatch_cnt    = 0;
    result_cnt      = 0;
    stall_cnt       = 0;
    hold_req        = 0;
    hold_left       = 0;
    idle_on         = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_lanes();
    test_random_lanes();
    test_idle_free_stream();
    test_result_backpressure();
    test_drain_pause();

    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_cnt == 0 && lane_expect_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
